// ----- rtl/keypad_pattern_record_matcher_top_assert.svh -----
// Assertion macros for the keypad pattern record matcher.
`ifndef KEYPAD_PATTERN_RECORD_MATCHER_TOP_ASSERT_SVH
`define KEYPAD_PATTERN_RECORD_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KPRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KPRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/kprm_pkg.sv -----
// Shared types, constants and the keypad decode for the record matcher.
`default_nettype none
package kprm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_RECORDS = 64;
    localparam int LEN_W = 5;
    localparam int DIGITS_W = 64;
    localparam int REC_W = 6;
    localparam int BY_W = 2;
    localparam int OUT_TDATA_W = 16;

    localparam logic [3:0] NO_KEY = 4'd15;
    localparam logic [3:0] MAX_DIGIT = 4'd9;
    localparam logic [3:0] SILENT_DIGIT = 4'd1;

    localparam logic [BY_W-1:0] BY_NONE = 2'd0;
    localparam logic [BY_W-1:0] BY_NUMBER = 2'd1;
    localparam logic [BY_W-1:0] BY_NAME = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_DIGITS = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    localparam logic [REC_W-1:0] LAST_RECORD = REC_W'(MAX_RECORDS - 1);

    typedef struct packed {
        logic [MAX_PATTERN-1:0] num_vec;
        logic [MAX_PATTERN-1:0] name_vec;
        logic                   num_hit;
        logic                   name_hit;
    } match_state_t;

    // Keypad digit of a byte; letters of either case, '+' maps to zero.
    function automatic logic [3:0] key_of_byte(input logic [7:0] c);
        logic [7:0] lc;
        logic [3:0] key;
        lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
        unique case (lc) inside
            [8'h61:8'h63]: key = 4'd2;
            [8'h64:8'h66]: key = 4'd3;
            [8'h67:8'h69]: key = 4'd4;
            [8'h6A:8'h6C]: key = 4'd5;
            [8'h6D:8'h6F]: key = 4'd6;
            [8'h70:8'h73]: key = 4'd7;
            [8'h74:8'h76]: key = 4'd8;
            [8'h77:8'h7A]: key = 4'd9;
            8'h2B:         key = 4'd0;
            default:       key = NO_KEY;
        endcase
        return key;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/kprm_step.sv -----
// One shift-and step of the number and name match vectors for a single byte.
`default_nettype none
module kprm_step (
    input  wire logic [7:0]                        ch,
    input  wire logic                              in_number,
    input  wire logic [kprm_pkg::DIGITS_W-1:0]     pattern_digits,
    input  wire logic [kprm_pkg::LEN_W-1:0]        pattern_length,
    input  wire kprm_pkg::match_state_t            cur,
    output kprm_pkg::match_state_t                 nxt
);

    logic [kprm_pkg::LEN_W-1:0]     len_eff;
    logic [kprm_pkg::MAX_PATTERN-1:0] len_mask;
    logic [kprm_pkg::MAX_PATTERN-1:0] top_mask;
    logic [kprm_pkg::MAX_PATTERN-1:0] accept;
    logic [kprm_pkg::MAX_PATTERN-1:0] shifted;
    logic [kprm_pkg::MAX_PATTERN-1:0] vec_new;
    logic [3:0]                     key;

    always_comb begin
        if (pattern_length == '0) begin
            len_eff = kprm_pkg::LEN_W'(1);
        end else if (pattern_length > kprm_pkg::LEN_W'(kprm_pkg::MAX_PATTERN)) begin
            len_eff = kprm_pkg::LEN_W'(kprm_pkg::MAX_PATTERN);
        end else begin
            len_eff = pattern_length;
        end
    end

    assign key = kprm_pkg::key_of_byte(ch);

    always_comb begin
        for (int j = 0; j < kprm_pkg::MAX_PATTERN; j++) begin
            logic [3:0] d;
            d = pattern_digits[4*j +: 4];
            len_mask[j] = (kprm_pkg::LEN_W'(j) < len_eff);
            top_mask[j] = (kprm_pkg::LEN_W'(j + 1) == len_eff);
            if (d > kprm_pkg::MAX_DIGIT) begin
                accept[j] = 1'b0;
            end else if (in_number) begin
                accept[j] = (ch == (8'h30 + {4'd0, d}));
            end else begin
                accept[j] = (d != kprm_pkg::SILENT_DIGIT) && (key == d);
            end
        end
    end

    // Only the vector of the byte's own field advances.
    assign shifted = in_number ? {cur.num_vec[kprm_pkg::MAX_PATTERN-2:0], 1'b1}
                               : {cur.name_vec[kprm_pkg::MAX_PATTERN-2:0], 1'b1};
    assign vec_new = shifted & accept & len_mask;

    always_comb begin
        nxt = cur;
        if (in_number) begin
            nxt.num_vec = vec_new;
            nxt.num_hit = cur.num_hit | (|(vec_new & top_mask));
        end else begin
            nxt.name_vec = vec_new;
            nxt.name_hit = cur.name_hit | (|(vec_new & top_mask));
        end
    end

endmodule
`default_nettype wire

// ----- rtl/keypad_pattern_record_matcher_top.sv -----
// Keypad pattern record matcher: stream of record bytes in, one result per record out.
//
// Input channel s_*: one record byte per item; s_tuser says whether it is a
// number byte (1) or a name byte (0), and s_tlast marks the last byte of a
// record. The configured digit pattern is searched as a plain substring of the
// number bytes and, through the phone keypad letters, of the name bytes.
// Output channel m_*: one item per record, sent after its last byte, carrying
// the record index and how it matched (number takes priority over name).
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 pattern
// digits, 1 pattern length) at a clock edge; write only while the block idles.
// A byte is registered at input, then the match step runs between the input
// register and the output register, which drives m_tvalid for the record.
// Throughput: one byte per cycle, except while a last byte is held at input
// for a pending result; the match step itself is combinational.
// Reset (aresetn low, synchronous) clears the vectors, hit flags, the record
// counter and both valid flags; pattern registers return to digits 0, length 1.
// When m_tready is low with a result pending, bytes keep flowing until the last
// byte of the next record reaches the input stage; it is held there and
// s_tready drops until the pending result is taken.
`default_nettype none
module keypad_pattern_record_matcher_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_addr,
    input  wire logic [kprm_pkg::DIGITS_W-1:0]       cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // ch
    input  wire logic                                s_tuser,   // in_number
    input  wire logic                                s_tlast,   // end_of_record
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // record_index[5:0], matched[6], matched_by[8:7], zero fill
    output logic [kprm_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    logic [kprm_pkg::DIGITS_W-1:0] digits_reg;
    logic [kprm_pkg::LEN_W-1:0]    length_reg;

    logic                          in_valid_reg;
    logic [7:0]                    in_ch_reg;
    logic                          in_num_reg;
    logic                          in_last_reg;

    kprm_pkg::match_state_t        state_reg;
    kprm_pkg::match_state_t        state_next;
    logic [kprm_pkg::REC_W-1:0]    rec_cnt_reg;

    logic                          out_valid_reg;
    logic [kprm_pkg::REC_W-1:0]    out_index_reg;
    logic                          out_matched_reg;
    logic [kprm_pkg::BY_W-1:0]     out_by_reg;

    logic                          advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg <= '0;
            length_reg <= kprm_pkg::LEN_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                kprm_pkg::CFG_DIGITS: digits_reg <= cfg_wdata;
                kprm_pkg::CFG_LENGTH: length_reg <= cfg_wdata[kprm_pkg::LEN_W-1:0];
                default:              digits_reg <= digits_reg;
            endcase
        end
    end

    // Only a last byte needs the output register; other bytes always move on.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg   <= s_tdata;
            in_num_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    kprm_step u_step (
        .ch             (in_ch_reg),
        .in_number      (in_num_reg),
        .pattern_digits (digits_reg),
        .pattern_length (length_reg),
        .cur            (state_reg),
        .nxt            (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            rec_cnt_reg <= '0;
        end else if (advance) begin
            if (in_last_reg) begin
                state_reg   <= '0;
                rec_cnt_reg <= (rec_cnt_reg == kprm_pkg::LAST_RECORD) ? '0
                             : rec_cnt_reg + kprm_pkg::REC_W'(1);
            end else begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_index_reg   <= rec_cnt_reg;
            out_matched_reg <= state_next.num_hit | state_next.name_hit;
            if (state_next.num_hit) begin
                out_by_reg <= kprm_pkg::BY_NUMBER;
            end else if (state_next.name_hit) begin
                out_by_reg <= kprm_pkg::BY_NAME;
            end else begin
                out_by_reg <= kprm_pkg::BY_NONE;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_by_reg, out_matched_reg, out_index_reg};

`include "keypad_pattern_record_matcher_top_assert.svh"

    `KPRM_ASSERT_NOW(a_matched_agrees, out_valid_reg, out_matched_reg == (out_by_reg != kprm_pkg::BY_NONE), "matched flag disagrees with matched_by")
    `KPRM_ASSERT_NEXT(a_clear_after_record, advance && in_last_reg, state_reg == '0, "match state not cleared after a record")
    `KPRM_ASSERT_NEXT(a_counter_steps, advance && in_last_reg, rec_cnt_reg == kprm_pkg::REC_W'($past(rec_cnt_reg) + 1), "record counter did not advance")

endmodule
`default_nettype wire
